/* src/tksp_pkg.sv */
// ----------------------------------------------------------------------------
// Timed key script player package
// Shared types, command and event codes for the script player.
// ----------------------------------------------------------------------------
package tksp_pkg;

    // Default number of script slots.
    localparam int DEFAULT_SCRIPT_DEPTH = 256;

    // Command codes carried on an input beat.
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [1:0] CMD_WRITE    = 2'd2;

    // Event codes carried on an output beat.
    localparam logic [1:0] EVT_NONE     = 2'd0;
    localparam logic [1:0] EVT_HELD     = 2'd1;
    localparam logic [1:0] EVT_RELEASED = 2'd2;

    // One script entry as it is stored.
    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] hold;
        logic [15:0] gap;
    } entry_t;

    // One result beat.
    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] key_row;
        logic [7:0] key_col;
        logic       playing;
    } result_t;

    // Pipeline control handed from the top level to the sequencer.
    typedef struct packed {
        logic accept;   // an input beat is taken this cycle
        logic advance;  // the item in the execute stage completes this cycle
    } seq_ctl_t;

endpackage

/* src/timed_key_script_player_unit.sv */
// ----------------------------------------------------------------------------
// Timed key script player
// Plays back a stored script of key presses against a millisecond clock.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless the clearing sweep or a stalled
// output holds it back, and returns exactly one result beat per item via
// the execute stage and the output register. Write items load script slots,
// an activate item starts playback, and tick items step the player: a tick
// fetches the next entry, reports the current key as held, reports it as
// released once the hold time is exceeded, or moves on once the gap time
// after the release is exceeded. An entry with a zero hold time ends the
// script, as does running off the end of the memory. After reset the script
// memory is swept to zero, one slot per cycle, with in_ready low until the
// sweep is done. The rate of one item per cycle rests on the single read
// port of the script memory: each item reads the slot at the position left
// by the item ahead, forwarded from the execute stage into the read address.
module timed_key_script_player_unit #(
    parameter int SCRIPT_DEPTH = tksp_pkg::DEFAULT_SCRIPT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] now_ms,
    input  logic        post_clear,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  entry_row,
    input  logic [7:0]  entry_col,
    input  logic [15:0] entry_hold_ms,
    input  logic [15:0] entry_gap_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [7:0]  key_row,
    output logic [7:0]  key_col,
    output logic        playing
);
    import tksp_pkg::*;

    localparam int AW = $clog2(SCRIPT_DEPTH);
    localparam int PW = $clog2(SCRIPT_DEPTH + 1);

    logic     s1_valid_reg, s1_valid_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_data_reg;
    result_t  result;
    seq_ctl_t ctl;
    logic     mem_busy;
    logic     wr_en;
    logic [AW-1:0] rd_addr;
    entry_t   wr_data;
    entry_t   rd_data;

    // The execute stage completes when the output register is free or is
    // being emptied in the same cycle; a new beat enters behind it.
    assign ctl.advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !mem_busy && (!s1_valid_reg || ctl.advance);
    assign ctl.accept  = in_valid && in_ready;

    // Writes land in memory at acceptance, so any later item reads them and
    // no earlier item can be affected. Slots past the end are dropped.
    assign wr_en = ctl.accept && (cmd == CMD_WRITE)
                   && (32'(entry_index) < 32'(SCRIPT_DEPTH));
    assign wr_data = '{row: entry_row, col: entry_col,
                       hold: entry_hold_ms, gap: entry_gap_ms};

    tksp_script_mem #(
        .SCRIPT_DEPTH (SCRIPT_DEPTH),
        .AW           (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_data (wr_data),
        .rd_en   (ctl.accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (mem_busy)
    );

    tksp_sequencer #(
        .SCRIPT_DEPTH (SCRIPT_DEPTH),
        .AW           (AW),
        .PW           (PW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cmd        (cmd),
        .now_ms     (now_ms),
        .post_clear (post_clear),
        .rd_data    (rd_data),
        .rd_addr    (rd_addr),
        .result     (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ctl.accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (ctl.advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (ctl.advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_data_reg.event_kind;
    assign key_row    = out_data_reg.key_row;
    assign key_col    = out_data_reg.key_col;
    assign playing    = out_data_reg.playing;

endmodule

/* src/tksp_script_mem.sv */
// ----------------------------------------------------------------------------
// Script memory
// Single-port-write, single-port-read synchronous memory of script entries
// with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tksp_script_mem #(
    parameter int SCRIPT_DEPTH = tksp_pkg::DEFAULT_SCRIPT_DEPTH,
    parameter int AW           = $clog2(SCRIPT_DEPTH)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tksp_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output tksp_pkg::entry_t rd_data,
    output logic            busy
);
    import tksp_pkg::*;

    entry_t          mem [SCRIPT_DEPTH];
    entry_t          rd_data_reg;
    logic            clearing_reg;
    logic            clearing_next;
    logic [AW-1:0]   clr_addr_reg;
    logic [AW-1:0]   clr_addr_next;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;

    // The sweep writes zero to one entry per cycle until the last one.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(SCRIPT_DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        mem_we    = clearing_reg | wr_en;
        mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clearing_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

/* src/tksp_sequencer.sv */
// ----------------------------------------------------------------------------
// Playback sequencer
// Execute stage: holds the playback state and turns one item plus the
// script entry read for it into one result.
// ----------------------------------------------------------------------------
module tksp_sequencer #(
    parameter int SCRIPT_DEPTH = tksp_pkg::DEFAULT_SCRIPT_DEPTH,
    parameter int AW           = $clog2(SCRIPT_DEPTH),
    parameter int PW           = $clog2(SCRIPT_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tksp_pkg::seq_ctl_t ctl,
    input  logic [1:0]         cmd,
    input  logic [31:0]        now_ms,
    input  logic               post_clear,
    input  tksp_pkg::entry_t   rd_data,
    output logic [AW-1:0]      rd_addr,
    output tksp_pkg::result_t  result
);
    import tksp_pkg::*;

    // Item held in the execute stage.
    logic [1:0]  s1_cmd_reg;
    logic [31:0] s1_now_reg;
    logic        s1_post_clear_reg;

    // Playback state.
    logic          playing_reg,  playing_next;
    logic          holding_reg,  holding_next;
    logic [PW-1:0] pos_reg,      pos_next;
    logic [31:0]   start_reg,    start_next;
    logic [15:0]   hold_lim_reg, hold_lim_next;
    logic [15:0]   gap_lim_reg,  gap_lim_next;

    logic [31:0]   elapsed;
    logic [PW-1:0] pos_fwd;
    logic          tick_live;

    assign elapsed   = s1_now_reg - start_reg;
    assign tick_live = (s1_cmd_reg == CMD_TICK) && !s1_post_clear_reg && playing_reg;

    always_comb
    begin
        playing_next  = playing_reg;
        holding_next  = holding_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;
        hold_lim_next = hold_lim_reg;
        gap_lim_next  = gap_lim_reg;
        result        = '0;
        case (s1_cmd_reg)
            CMD_TICK:
            begin
                if (tick_live)
                begin
                    if (hold_lim_reg == 16'd0)
                    begin
                        // Fetch the entry at the current position.
                        if (pos_reg >= PW'(SCRIPT_DEPTH))
                        begin
                            pos_next     = '0;
                            playing_next = 1'b0;
                        end
                        else
                        begin
                            hold_lim_next = rd_data.hold;
                            gap_lim_next  = rd_data.gap;
                            if (rd_data.hold == 16'd0)
                            begin
                                pos_next     = '0;
                                playing_next = 1'b0;
                            end
                            else
                            begin
                                holding_next = 1'b1;
                                start_next   = s1_now_reg;
                            end
                        end
                    end
                    else if (holding_reg && (elapsed > 32'(hold_lim_reg)))
                    begin
                        holding_next      = 1'b0;
                        start_next        = s1_now_reg;
                        result.event_kind = EVT_RELEASED;
                        result.key_row    = rd_data.row;
                        result.key_col    = rd_data.col;
                    end
                    else if (holding_reg)
                    begin
                        result.event_kind = EVT_HELD;
                        result.key_row    = rd_data.row;
                        result.key_col    = rd_data.col;
                    end
                    else if (elapsed > 32'(gap_lim_reg))
                    begin
                        pos_next      = pos_reg + PW'(1);
                        hold_lim_next = 16'd0;
                    end
                end
            end
            CMD_ACTIVATE:
            begin
                playing_next = 1'b1;
            end
            default:
            begin
            end
        endcase
        result.playing = playing_next;
    end

    // The read for the next item uses the position this item leaves behind.
    // A position past the end reads slot zero, whose data then goes unused.
    assign pos_fwd = ctl.advance ? pos_next : pos_reg;
    assign rd_addr = (pos_fwd >= PW'(SCRIPT_DEPTH)) ? '0 : pos_fwd[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            s1_cmd_reg        <= cmd;
            s1_now_reg        <= now_ms;
            s1_post_clear_reg <= post_clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg  <= 1'b0;
            holding_reg  <= 1'b0;
            pos_reg      <= '0;
            start_reg    <= '0;
            hold_lim_reg <= '0;
            gap_lim_reg  <= '0;
        end
        else if (ctl.advance)
        begin
            playing_reg  <= playing_next;
            holding_reg  <= holding_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            hold_lim_reg <= hold_lim_next;
            gap_lim_reg  <= gap_lim_next;
        end
    end

endmodule
